@@ design/assert_macros.svh @@
// Assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define TOTP_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("totp assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define TOTP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	`TOTP_ASSERT(name, clk, rst_n, (ante) |-> (cons))

`endif

@@ design/totp_pkg.sv @@
// Shared types, constants and functions of the TOTP code generator
`default_nettype none
package totp_pkg;

	localparam int MAX_KEY_BYTES_DEF = 64;

	localparam int KEY_LEN_W   = 7;
	localparam int HASH_SEL_W  = 2;
	localparam int DIGITS_W    = 4;
	localparam int STEP_W      = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int KWI_W       = 3;
	localparam int KW_W        = 64;
	localparam int TS_W        = 63;
	localparam int CODE_W      = 30;
	localparam int DIVISOR_W   = 30;
	localparam int DIGEST_W    = 512;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SELECT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DIGITS  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SECONDS = 2'd3;

	localparam logic OP_KEY_WRITE = 1'b0;
	localparam logic OP_CODE      = 1'b1;

	localparam logic [HASH_SEL_W-1:0] ALG_SHA1   = 2'd0;
	localparam logic [HASH_SEL_W-1:0] ALG_SHA256 = 2'd1;
	localparam logic [HASH_SEL_W-1:0] ALG_SHA512 = 2'd2;
	localparam logic [HASH_SEL_W-1:0] ALG_BAD    = 2'd3;

	localparam logic [DIGITS_W-1:0] MAX_DIGITS = 4'd9;

	typedef struct packed {
		logic                  init;
		logic [HASH_SEL_W-1:0] alg;
		logic                  wr;
		logic [3:0]            wr_idx;
		logic [63:0]           wr_data;
		logic                  start;
	} hash_cmd_t;

	typedef struct packed {
		logic                busy;
		logic [DIGEST_W-1:0] digest;
	} hash_stat_t;

	typedef struct packed {
		logic                 start;
		logic [TS_W-1:0]      dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                 busy;
		logic [TS_W-1:0]      quotient;
		logic [DIVISOR_W-1:0] remainder;
	} div_stat_t;

	function automatic logic [DIVISOR_W-1:0] pow10(input logic [DIGITS_W-1:0] d);
		logic [DIVISOR_W-1:0] m;
		case (d)
			4'd0:    m = 30'd1;
			4'd1:    m = 30'd10;
			4'd2:    m = 30'd100;
			4'd3:    m = 30'd1000;
			4'd4:    m = 30'd10000;
			4'd5:    m = 30'd100000;
			4'd6:    m = 30'd1000000;
			4'd7:    m = 30'd10000000;
			4'd8:    m = 30'd100000000;
			default: m = 30'd1000000000;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ design/totp_if.sv @@
// Handshake channel interfaces for request and code words
`default_nettype none
interface totp_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [totp_pkg::KWI_W-1:0] key_word_index;
	logic [totp_pkg::KW_W-1:0]  key_word;
	logic [totp_pkg::TS_W-1:0]  timestamp;
	modport source (output valid, op, key_word_index, key_word, timestamp, input ready);
	modport sink (input valid, op, key_word_index, key_word, timestamp, output ready);
endinterface

interface totp_out_if;
	logic                        valid;
	logic                        ready;
	logic [totp_pkg::CODE_W-1:0] code;
	modport source (output valid, code, input ready);
	modport sink (input valid, code, output ready);
endinterface
`default_nettype wire

@@ design/totp_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module totp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/totp_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none
module totp_div import totp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_cmd_t  cmd,
	output div_stat_t stat
);
	logic                 run_q;
	logic [5:0]           cnt_q;
	logic [TS_W-1:0]      q_q;
	logic [DIVISOR_W-1:0] r_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [DIVISOR_W:0]   r_sh;
	logic [DIVISOR_W:0]   r_sub;
	logic                 qbit;
	logic [DIVISOR_W-1:0] r_nxt;

	always_comb begin
		r_sh  = {r_q, q_q[TS_W-1]};
		r_sub = r_sh - {1'b0, d_q};
		qbit  = (r_sh >= {1'b0, d_q});
		r_nxt = qbit ? r_sub[DIVISOR_W-1:0] : r_sh[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			run_q <= 1'b1;
			cnt_q <= 6'(TS_W - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q <= cmd.dividend;
			r_q <= '0;
			d_q <= cmd.divisor;
		end else if (run_q) begin
			q_q <= {q_q[TS_W-2:0], qbit};
			r_q <= r_nxt;
		end
	end

	assign stat.busy      = run_q;
	assign stat.quotient  = q_q;
	assign stat.remainder = r_q;
endmodule
`default_nettype wire

@@ design/totp_hash.sv @@
// Iterative SHA-1 / SHA-256 / SHA-512 compression engine, one round per cycle
`default_nettype none
module totp_hash import totp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hash_cmd_t  cmd,
	output hash_stat_t stat
);
	logic [63:0]           h_q [8];
	logic [63:0]           v_q [8];
	logic [63:0]           win_q [16];
	logic [6:0]            rnd_q;
	logic                  run_q;
	logic                  fin_q;
	logic [HASH_SEL_W-1:0] alg_q;
	logic [6:0]            last_rnd;
	logic [63:0]           v_nxt [8];
	logic [63:0]           w_nxt;
	logic [63:0]           kc;
	logic [63:0]           t1, t2;
	logic [31:0]           u1, u2, f1, k1;
	logic [DIGEST_W-1:0]   dig;

	function automatic logic [31:0] rr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [63:0] rr64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] iv(input logic [HASH_SEL_W-1:0] alg, input int j);
		logic [63:0] v5 [8];
		logic [31:0] s1 [5];
		v5 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
			64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
			64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
		s1 = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
		if (alg == ALG_SHA512) begin
			return v5[j];
		end else if (alg == ALG_SHA256) begin
			return {32'b0, v5[j][63:32]};
		end
		return (j < 5) ? {32'b0, s1[j]} : 64'b0;
	endfunction

	function automatic logic [63:0] k_const(input logic [6:0] i);
		logic [63:0] k;
		case (i)
			7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
			7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
			7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
			7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
			7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

	assign last_rnd = (alg_q == ALG_SHA256) ? 7'd63 : 7'd79;

	always_comb begin
		kc = k_const(rnd_q);
		v_nxt = v_q;
		t1 = '0;
		t2 = '0;
		u1 = '0;
		u2 = '0;
		f1 = '0;
		k1 = '0;
		w_nxt = '0;
		case (alg_q)
			ALG_SHA512: begin
				t1 = v_q[7] + (rr64(v_q[4], 14) ^ rr64(v_q[4], 18) ^ rr64(v_q[4], 41))
					+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kc + win_q[0];
				t2 = (rr64(v_q[0], 28) ^ rr64(v_q[0], 34) ^ rr64(v_q[0], 39))
					+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
				v_nxt[7] = v_q[6];
				v_nxt[6] = v_q[5];
				v_nxt[5] = v_q[4];
				v_nxt[4] = v_q[3] + t1;
				v_nxt[3] = v_q[2];
				v_nxt[2] = v_q[1];
				v_nxt[1] = v_q[0];
				v_nxt[0] = t1 + t2;
				w_nxt = (rr64(win_q[14], 19) ^ rr64(win_q[14], 61) ^ (win_q[14] >> 6))
					+ win_q[9]
					+ (rr64(win_q[1], 1) ^ rr64(win_q[1], 8) ^ (win_q[1] >> 7)) + win_q[0];
			end
			ALG_SHA256: begin
				u1 = v_q[7][31:0]
					+ (rr32(v_q[4][31:0], 6) ^ rr32(v_q[4][31:0], 11) ^ rr32(v_q[4][31:0], 25))
					+ ((v_q[4][31:0] & v_q[5][31:0]) ^ (~v_q[4][31:0] & v_q[6][31:0]))
					+ kc[63:32] + win_q[0][31:0];
				u2 = (rr32(v_q[0][31:0], 2) ^ rr32(v_q[0][31:0], 13) ^ rr32(v_q[0][31:0], 22))
					+ ((v_q[0][31:0] & v_q[1][31:0]) ^ (v_q[0][31:0] & v_q[2][31:0])
					^ (v_q[1][31:0] & v_q[2][31:0]));
				v_nxt[7] = v_q[6];
				v_nxt[6] = v_q[5];
				v_nxt[5] = v_q[4];
				v_nxt[4] = {32'b0, v_q[3][31:0] + u1};
				v_nxt[3] = v_q[2];
				v_nxt[2] = v_q[1];
				v_nxt[1] = v_q[0];
				v_nxt[0] = {32'b0, u1 + u2};
				w_nxt = {32'b0,
					(rr32(win_q[14][31:0], 17) ^ rr32(win_q[14][31:0], 19)
					^ (win_q[14][31:0] >> 10)) + win_q[9][31:0]
					+ (rr32(win_q[1][31:0], 7) ^ rr32(win_q[1][31:0], 18)
					^ (win_q[1][31:0] >> 3)) + win_q[0][31:0]};
			end
			default: begin
				if (rnd_q < 7'd20) begin
					f1 = (v_q[1][31:0] & v_q[2][31:0]) | (~v_q[1][31:0] & v_q[3][31:0]);
					k1 = 32'h5a827999;
				end else if (rnd_q < 7'd40) begin
					f1 = v_q[1][31:0] ^ v_q[2][31:0] ^ v_q[3][31:0];
					k1 = 32'h6ed9eba1;
				end else if (rnd_q < 7'd60) begin
					f1 = (v_q[1][31:0] & v_q[2][31:0]) | (v_q[1][31:0] & v_q[3][31:0])
						| (v_q[2][31:0] & v_q[3][31:0]);
					k1 = 32'h8f1bbcdc;
				end else begin
					f1 = v_q[1][31:0] ^ v_q[2][31:0] ^ v_q[3][31:0];
					k1 = 32'hca62c1d6;
				end
				u1 = rr32(v_q[0][31:0], 27) + f1 + v_q[4][31:0] + k1 + win_q[0][31:0];
				v_nxt[4] = v_q[3];
				v_nxt[3] = v_q[2];
				v_nxt[2] = {32'b0, rr32(v_q[1][31:0], 2)};
				v_nxt[1] = v_q[0];
				v_nxt[0] = {32'b0, u1};
				w_nxt = {32'b0, rr32(win_q[13][31:0] ^ win_q[8][31:0] ^ win_q[2][31:0]
					^ win_q[0][31:0], 31)};
			end
		endcase
	end

	always_comb begin
		dig = '0;
		for (int j = 0; j < 8; j++) begin
			if (alg_q == ALG_SHA512) begin
				dig[DIGEST_W-1-64*j -: 64] = h_q[j];
			end else begin
				dig[DIGEST_W-1-32*j -: 32] = h_q[j][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
			alg_q <= ALG_SHA1;
		end else begin
			if (cmd.init) begin
				alg_q <= cmd.alg;
			end
			if (cmd.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == last_rnd) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 8; j++) begin
			if (cmd.init) begin
				h_q[j] <= iv(cmd.alg, j);
			end else if (fin_q) begin
				if (alg_q == ALG_SHA512) begin
					h_q[j] <= h_q[j] + v_q[j];
				end else begin
					h_q[j] <= {32'b0, h_q[j][31:0] + v_q[j][31:0]};
				end
			end
			if (cmd.start) begin
				v_q[j] <= h_q[j];
			end else if (run_q) begin
				v_q[j] <= v_nxt[j];
			end
		end
		if (cmd.wr) begin
			win_q[cmd.wr_idx] <= cmd.wr_data;
		end else if (run_q) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[15] <= w_nxt;
		end
	end

	assign stat.busy   = run_q | fin_q;
	assign stat.digest = dig;
endmodule
`default_nettype wire

@@ design/totp_code_generator.sv @@
// TOTP code generator top level: key store, sequencer, divider and hash engine
//
//   channel   dir   word                                   handshake
//   cmd       in    op, key_word_index, key_word, timestamp valid/ready
//   result    out   code                                    valid/ready
//   cfg       in    cfg_index, cfg_data                     cfg_we
//
// A key write goes straight into the key store when it is accepted. A code request runs
// 63 divider steps for the counter, then four blocks, each a key-store/window load,
// 80 hash rounds (64 for SHA-256) and the digest update, and then 63 divider steps
// for the modulo.
// Reset restores the register defaults and clears the key valid bits.
// The next word is taken once the code word has left the output register.
`default_nettype none
`include "assert_macros.svh"
module totp_code_generator import totp_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	totp_in_if.sink                cmd,
	totp_out_if.source             result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
	localparam int KW_AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam logic [KEY_LEN_W-1:0] MAX_KL = KEY_LEN_W'(MAX_KEY_BYTES);
	localparam logic [3:0] KEY_WORDS_C = 4'(KEY_WORDS);

	localparam logic [1:0] BLK_IKEY = 2'd0;
	localparam logic [1:0] BLK_CTR  = 2'd1;
	localparam logic [1:0] BLK_OKEY = 2'd2;
	localparam logic [1:0] BLK_DIG  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_LOAD, ST_RUN, ST_TRUNC, ST_MOD, ST_OUT
	} state_t;

	state_t                state_q;
	logic [4:0]            cnt_q;
	logic [1:0]            blk_q;
	logic [CODE_W-1:0]     code_q;
	logic                  ovalid_q;
	logic [KEY_WORDS-1:0]  valid_q;

	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [HASH_SEL_W-1:0] hash_select_q;
	logic [DIGITS_W-1:0]   code_digits_q;
	logic [STEP_W-1:0]     step_seconds_q;

	logic [63:0]           ctr_q;
	logic [DIGEST_W-1:0]   dig_q;
	logic [3:0]            slot_s1;
	logic [2:0]            kidx_s1;
	logic                  kin_s1;

	logic                  accept;
	logic                  ram_we;
	logic [KW_AW-1:0]      ram_raddr;
	logic [KW_W-1:0]       ram_rdata;
	logic [HASH_SEL_W-1:0] alg_n;
	logic [KEY_LEN_W-1:0]  kl_n;
	logic [DIGITS_W-1:0]   digits_n;
	logic [STEP_W-1:0]     step_n;
	logic [3:0]            slot;
	logic [2:0]            kidx;
	logic                  kin;
	logic [63:0]           kw;
	logic [63:0]           pad64;
	logic [63:0]           sw;
	logic [DIGEST_W-1:0]   dsh;
	logic [7:0]            last_byte;
	logic [DIGEST_W-1:0]   tsh;
	logic [30:0]           val;
	hash_cmd_t             hcmd;
	hash_stat_t            hstat;
	div_cmd_t              dcmd;
	div_stat_t             dstat;

	assign accept  = cmd.valid && cmd.ready;
	assign ram_we  = accept && (cmd.op == OP_KEY_WRITE)
		&& ({1'b0, cmd.key_word_index} < KEY_WORDS_C);

	assign alg_n    = (hash_select_q == ALG_BAD) ? ALG_SHA1 : hash_select_q;
	assign kl_n     = (key_length_q > MAX_KL) ? MAX_KL : key_length_q;
	assign digits_n = (code_digits_q > MAX_DIGITS) ? MAX_DIGITS : code_digits_q;
	assign step_n   = (step_seconds_q == '0) ? STEP_W'(1) : step_seconds_q;

	// key word feeding each window slot
	assign slot = cnt_q[3:0];
	always_comb begin
		if (alg_n == ALG_SHA512) begin
			kidx = slot[2:0];
			kin  = !slot[3];
		end else begin
			kidx = slot[3:1];
			kin  = 1'b1;
		end
		kin = kin && ({1'b0, kidx} < KEY_WORDS_C);
	end
	assign ram_raddr = kidx[KW_AW-1:0];

	totp_ram #(
		.WIDTH (KW_W),
		.DEPTH (KEY_WORDS)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.key_word_index[KW_AW-1:0]),
		.wdata (cmd.key_word),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		kw = (kin_s1 && valid_q[kidx_s1[KW_AW-1:0]]) ? ram_rdata : 64'b0;
		for (int b = 0; b < 8; b++) begin
			if ({1'b0, kidx_s1, 3'(b)} >= kl_n) begin
				kw[63-8*b -: 8] = 8'h00;
			end
		end
	end

	// window word for the slot being loaded
	always_comb begin
		pad64 = blk_q[1] ? {8{8'h5c}} : {8{8'h36}};
		dsh = '0;
		sw = '0;
		case (blk_q)
			BLK_IKEY, BLK_OKEY: begin
				if (alg_n == ALG_SHA512) begin
					sw = slot_s1[3] ? pad64 : (kw ^ pad64);
				end else begin
					sw = {32'b0, (slot_s1[0] ? kw[31:0] : kw[63:32]) ^ pad64[31:0]};
				end
			end
			BLK_CTR: begin
				if (alg_n == ALG_SHA512) begin
					if (slot_s1 == 4'd0) sw = ctr_q;
					else if (slot_s1 == 4'd1) sw = 64'h8000000000000000;
					else if (slot_s1 == 4'd15) sw = 64'd1088;
				end else begin
					if (slot_s1 == 4'd0) sw = {32'b0, ctr_q[63:32]};
					else if (slot_s1 == 4'd1) sw = {32'b0, ctr_q[31:0]};
					else if (slot_s1 == 4'd2) sw = 64'h80000000;
					else if (slot_s1 == 4'd15) sw = 64'd576;
				end
			end
			default: begin
				if (alg_n == ALG_SHA512) begin
					dsh = dig_q << {slot_s1[2:0], 6'b0};
					if (!slot_s1[3]) sw = dsh[DIGEST_W-1 -: 64];
					else if (slot_s1 == 4'd8) sw = 64'h8000000000000000;
					else if (slot_s1 == 4'd15) sw = 64'd1536;
				end else begin
					dsh = dig_q << {slot_s1[2:0], 5'b0};
					if (alg_n == ALG_SHA1) begin
						if (slot_s1 < 4'd5) sw = {32'b0, dsh[DIGEST_W-1 -: 32]};
						else if (slot_s1 == 4'd5) sw = 64'h80000000;
						else if (slot_s1 == 4'd15) sw = 64'd672;
					end else begin
						if (!slot_s1[3]) sw = {32'b0, dsh[DIGEST_W-1 -: 32]};
						else if (slot_s1 == 4'd8) sw = 64'h80000000;
						else if (slot_s1 == 4'd15) sw = 64'd768;
					end
				end
			end
		endcase
	end

	// dynamic truncation of the final digest
	always_comb begin
		case (alg_n)
			ALG_SHA512: last_byte = hstat.digest[7:0];
			ALG_SHA256: last_byte = hstat.digest[263:256];
			default:    last_byte = hstat.digest[359:352];
		endcase
		tsh = hstat.digest << {last_byte[3:0], 3'b0};
		val = {tsh[DIGEST_W-2 -: 7], tsh[DIGEST_W-9 -: 24]};
	end

	always_comb begin
		hcmd.init    = (state_q == ST_LOAD) && (cnt_q == 5'd0) && !blk_q[0];
		hcmd.alg     = alg_n;
		hcmd.wr      = (state_q == ST_LOAD) && (cnt_q != 5'd0);
		hcmd.wr_idx  = slot_s1;
		hcmd.wr_data = sw;
		hcmd.start   = (state_q == ST_LOAD) && (cnt_q == 5'd16);

		dcmd.start = (accept && (cmd.op == OP_CODE)) || (state_q == ST_TRUNC);
		if (state_q == ST_IDLE) begin
			dcmd.dividend = cmd.timestamp;
			dcmd.divisor  = {{(DIVISOR_W-STEP_W){1'b0}}, step_n};
		end else begin
			dcmd.dividend = {{(TS_W-31){1'b0}}, val};
			dcmd.divisor  = pow10(digits_n);
		end
	end

	totp_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.stat   (hstat)
	);

	totp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.stat   (dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q   <= '0;
			hash_select_q  <= ALG_SHA1;
			code_digits_q  <= 4'd6;
			step_seconds_q <= 17'd30;
			valid_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LENGTH:  key_length_q   <= cfg_data[KEY_LEN_W-1:0];
					CFG_HASH_SELECT: hash_select_q  <= cfg_data[HASH_SEL_W-1:0];
					CFG_CODE_DIGITS: code_digits_q  <= cfg_data[DIGITS_W-1:0];
					default:         step_seconds_q <= cfg_data[STEP_W-1:0];
				endcase
			end
			if (ram_we) begin
				valid_q[cmd.key_word_index[KW_AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			blk_q    <= BLK_IKEY;
			ovalid_q <= 1'b0;
			code_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.op == OP_CODE)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!dstat.busy) begin
						blk_q   <= BLK_IKEY;
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!hstat.busy) begin
						if (blk_q == BLK_DIG) begin
							state_q <= ST_TRUNC;
						end else begin
							blk_q   <= blk_q + 2'd1;
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_TRUNC: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (!dstat.busy) begin
						code_q   <= dstat.remainder;
						ovalid_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						ovalid_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= slot;
		kidx_s1 <= kidx;
		kin_s1  <= kin;
		if ((state_q == ST_DIV) && !dstat.busy) begin
			ctr_q <= {1'b0, dstat.quotient};
		end
		if ((state_q == ST_RUN) && !hstat.busy && (blk_q == BLK_CTR)) begin
			dig_q <= hstat.digest;
		end
	end

	assign cmd.ready    = (state_q == ST_IDLE);
	assign result.valid = ovalid_q;
	assign result.code  = code_q;

	`TOTP_ASSERT_IMP(a_no_accept_pending, clk, arst_n, accept, !ovalid_q)
	`TOTP_ASSERT_IMP(a_hash_start_idle, clk, arst_n, hcmd.start, !hstat.busy)
	`TOTP_ASSERT_IMP(a_out_after_mod, clk, arst_n, $rose(ovalid_q), $past(state_q) == ST_MOD)
	`TOTP_ASSERT_IMP(a_div_start_idle, clk, arst_n, dcmd.start, !dstat.busy)
endmodule
`default_nettype wire
